// ===== hdl/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg
// shared codes and fixed widths for the vertex transform block
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int TOL_W   = 16;
    localparam int IDX_W   = 4;
    localparam int MAT_DIM = 4;
    localparam int MAT_N   = MAT_DIM * MAT_DIM;
    localparam int LANES   = 3;

    // quotient bits produced by the divider
    localparam int QUO_W = DATA_W;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    // tolerance after reset
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

    // signed 32-bit limits
    localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== hdl/vertex_transform_perspective.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_perspective
// 4x4 homogeneous vertex transform with perspective divide, signed fixed point
// ----------------------------------------------------------------------------
// One input channel (in_valid/in_ready) carries either a matrix element load
// (cmd 0) or a vertex (cmd 1). A load is written into the matrix at its
// transfer and gives no result; the next vertex already sees it. A vertex
// gives one result on the output channel (out_valid/out_ready).
// The configuration port (cfg_we/cfg_wdata) sets the w tolerance; the user
// must write it only while the block is idle, which the block does not enforce.
// A vertex passes through 36 register stages: one multiply stage, one sum
// stage, one prepare stage, one stage per quotient bit of the 32-stage
// restoring divider, and the output register.
// Throughput is one item per cycle while the output is not stalled; the
// divider is fully pipelined and its three lanes (x, y, z) work side by side.
// Reset loads the identity matrix, sets the tolerance to 16 and empties the
// pipeline. When the receiver stalls, a full stage holds while every stage
// after it is full, bubbles close up, and input stays open until all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [vtp_pkg::TOL_W-1:0]           cfg_wdata,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                cmd,
    input  wire logic [vtp_pkg::IDX_W-1:0]           elem_index,
    input  wire logic signed [vtp_pkg::DATA_W-1:0]   elem_value,
    input  wire logic signed [vtp_pkg::DATA_W-1:0]   vertex_x,
    input  wire logic signed [vtp_pkg::DATA_W-1:0]   vertex_y,
    input  wire logic signed [vtp_pkg::DATA_W-1:0]   vertex_z,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [vtp_pkg::DATA_W-1:0]        out_x,
    output logic signed [vtp_pkg::DATA_W-1:0]        out_y,
    output logic signed [vtp_pkg::DATA_W-1:0]        out_z,
    output logic                                     divide_skipped,
    output logic                                     saturated
);

    localparam int DW    = vtp_pkg::DATA_W;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW - FRAC_BITS + 2;
    localparam int NW    = SW + FRAC_BITS;
    localparam int HW    = NW - vtp_pkg::QUO_W;
    localparam int QW    = vtp_pkg::QUO_W;
    localparam int ND    = QW;
    localparam int NS    = ND + 4;
    localparam int LN    = vtp_pkg::LANES;
    localparam int MD    = vtp_pkg::MAT_DIM;
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    // matrix and tolerance
    logic signed [DW-1:0]          mat_reg [vtp_pkg::MAT_N];
    logic [vtp_pkg::TOL_W-1:0]     tol_reg;

    // stage valids and ready chain
    logic [NS:1]                   vld_reg;
    logic [NS:1]                   rdy;

    logic                          in_xfer;

    // stage 1: products
    logic signed [PW-1:0]          prod_reg [MD][LN];
    logic signed [DW-1:0]          col_reg  [MD];

    // stage 2: row sums
    logic signed [SW-1:0]          sum_reg  [MD];

    // divider stages, index 0 is the prepare stage
    logic [SW-1:0]                 b_reg     [0:ND];
    logic                          skip_reg  [0:ND];
    logic                          ssat_reg  [0:ND];
    logic [DW-1:0]                 sv_reg    [0:ND][LN];
    logic [SW-1:0]                 rem_reg   [0:ND][LN];
    logic [QW-1:0]                 lo_reg    [0:ND][LN];
    logic [QW-1:0]                 q_reg     [0:ND][LN];
    logic                          ovf_reg   [0:ND][LN];
    logic                          neg_reg   [0:ND][LN];
    logic                          zero_reg  [0:ND][LN];

    // ready chain, closes bubbles
    assign rdy[NS]  = !vld_reg[NS] || out_ready;
    genvar gk;
    generate
        for (gk = 1; gk < NS; gk++) begin : g_rdy
            assign rdy[gk] = !vld_reg[gk] || rdy[gk+1];
        end
    endgenerate

    assign in_ready = rdy[1];
    assign in_xfer  = in_valid && rdy[1];

    // matrix store and tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vtp_pkg::MAT_N; i++)
            begin
                mat_reg[i] <= ((i % (MD + 1)) == 0) ? ONE_Q : '0;
            end
            tol_reg <= vtp_pkg::TOL_RESET;
        end
        else
        begin
            if (in_xfer && cmd == vtp_pkg::CMD_LOAD)
            begin
                mat_reg[elem_index] <= elem_value;
            end
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= in_valid && cmd == vtp_pkg::CMD_VERTEX;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: one multiplier per matrix element of columns zero to two
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int r = 0; r < MD; r++)
            begin
                prod_reg[r][0] <= PW'(mat_reg[r*MD+0]) * PW'(vertex_x);
                prod_reg[r][1] <= PW'(mat_reg[r*MD+1]) * PW'(vertex_y);
                prod_reg[r][2] <= PW'(mat_reg[r*MD+2]) * PW'(vertex_z);
                col_reg[r]     <= mat_reg[r*MD+3];
            end
        end
    end

    // stage 2: floor shift and row sums
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int r = 0; r < MD; r++)
            begin
                sum_reg[r] <= SW'(prod_reg[r][0] >>> FRAC_BITS)
                            + SW'(prod_reg[r][1] >>> FRAC_BITS)
                            + SW'(prod_reg[r][2] >>> FRAC_BITS)
                            + SW'(col_reg[r]);
            end
        end
    end

    // stage 3: near test, clamp for skipped divide, divider setup
    logic signed [SW:0]  w_ext;
    logic [SW:0]         dw;
    logic [SW:0]         dw1;
    logic signed [SW:0]  wm1;
    logic                skip_c;
    logic                ssat_c;
    logic [DW-1:0]       sv_c   [LN];
    logic [SW-1:0]       a_c    [LN];
    logic [NW-1:0]       n_c    [LN];
    logic [HW-1:0]       hi_c   [LN];
    logic                ovf_c  [LN];
    logic [SW-1:0]       b_c;

    always_comb
    begin
        w_ext  = (SW+1)'(sum_reg[3]);
        wm1    = w_ext - (SW+1)'($signed(ONE_Q));
        dw     = w_ext[SW] ? (SW+1)'(-w_ext) : w_ext;
        dw1    = wm1[SW] ? (SW+1)'(-wm1) : wm1;
        skip_c = (dw < (SW+1)'(tol_reg)) || (dw1 < (SW+1)'(tol_reg));
        b_c    = dw[SW-1:0];
        ssat_c = 1'b0;
        for (int l = 0; l < LN; l++)
        begin
            // clamp to signed 32 bits
            if (sum_reg[l] > SW'($signed(vtp_pkg::S32_MAX)))
            begin
                sv_c[l] = vtp_pkg::S32_MAX;
                ssat_c  = 1'b1;
            end
            else if (sum_reg[l] < SW'($signed(vtp_pkg::S32_MIN)))
            begin
                sv_c[l] = vtp_pkg::S32_MIN;
                ssat_c  = 1'b1;
            end
            else
            begin
                sv_c[l] = sum_reg[l][DW-1:0];
            end
            a_c[l]   = sum_reg[l][SW-1] ? SW'(-sum_reg[l]) : sum_reg[l];
            n_c[l]   = {a_c[l], {FRAC_BITS{1'b0}}};
            hi_c[l]  = n_c[l][NW-1:QW];
            ovf_c[l] = SW'(hi_c[l]) >= b_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            b_reg[0]    <= b_c;
            skip_reg[0] <= skip_c;
            ssat_reg[0] <= ssat_c;
            for (int l = 0; l < LN; l++)
            begin
                sv_reg[0][l]   <= sv_c[l];
                rem_reg[0][l]  <= ovf_c[l] ? '0 : SW'(hi_c[l]);
                lo_reg[0][l]   <= n_c[l][QW-1:0];
                q_reg[0][l]    <= '0;
                ovf_reg[0][l]  <= ovf_c[l];
                neg_reg[0][l]  <= sum_reg[l][SW-1] ^ sum_reg[3][SW-1];
                zero_reg[0][l] <= sum_reg[l] == '0;
            end
        end
    end

    // divider: one quotient bit per stage in each lane
    generate
        for (gk = 1; gk <= ND; gk++) begin : g_div
            logic [SW:0] trial [LN];
            logic        take  [LN];

            always_comb
            begin
                for (int l = 0; l < LN; l++)
                begin
                    trial[l] = {rem_reg[gk-1][l], lo_reg[gk-1][l][QW-1]};
                    take[l]  = trial[l] >= {1'b0, b_reg[gk-1]};
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[gk+3])
                begin
                    b_reg[gk]    <= b_reg[gk-1];
                    skip_reg[gk] <= skip_reg[gk-1];
                    ssat_reg[gk] <= ssat_reg[gk-1];
                    for (int l = 0; l < LN; l++)
                    begin
                        sv_reg[gk][l]   <= sv_reg[gk-1][l];
                        rem_reg[gk][l]  <= take[l]
                                         ? SW'(trial[l] - {1'b0, b_reg[gk-1]})
                                         : trial[l][SW-1:0];
                        lo_reg[gk][l]   <= {lo_reg[gk-1][l][QW-2:0], 1'b0};
                        q_reg[gk][l]    <= {q_reg[gk-1][l][QW-2:0], take[l]};
                        ovf_reg[gk][l]  <= ovf_reg[gk-1][l];
                        neg_reg[gk][l]  <= neg_reg[gk-1][l];
                        zero_reg[gk][l] <= zero_reg[gk-1][l];
                    end
                end
            end
        end
    endgenerate

    // output stage: sign, saturation, select
    logic [DW-1:0] res_c [LN];
    logic          sat_c;
    logic [QW:0]   qneg;

    always_comb
    begin
        sat_c = ssat_reg[ND] && skip_reg[ND];
        qneg  = '0;
        for (int l = 0; l < LN; l++)
        begin
            qneg = (QW+1)'(0) - {1'b0, q_reg[ND][l]};
            if (skip_reg[ND])
            begin
                res_c[l] = sv_reg[ND][l];
            end
            else if (zero_reg[ND][l])
            begin
                res_c[l] = '0;
            end
            else if (ovf_reg[ND][l])
            begin
                res_c[l] = neg_reg[ND][l] ? vtp_pkg::S32_MIN : vtp_pkg::S32_MAX;
                sat_c    = 1'b1;
            end
            else if (neg_reg[ND][l])
            begin
                if (q_reg[ND][l] > vtp_pkg::S32_MIN)
                begin
                    res_c[l] = vtp_pkg::S32_MIN;
                    sat_c    = 1'b1;
                end
                else
                begin
                    res_c[l] = qneg[DW-1:0];
                end
            end
            else if (q_reg[ND][l][QW-1])
            begin
                res_c[l] = vtp_pkg::S32_MAX;
                sat_c    = 1'b1;
            end
            else
            begin
                res_c[l] = q_reg[ND][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS])
        begin
            out_x          <= res_c[0];
            out_y          <= res_c[1];
            out_z          <= res_c[2];
            divide_skipped <= skip_reg[ND];
            saturated      <= sat_c;
        end
    end

    assign out_valid = vld_reg[NS];

endmodule

`default_nettype wire

// ===== sim/vertex_transform_perspective_test.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_perspective_test
// self-checking bench for the 4x4 vertex transform with perspective divide
// ----------------------------------------------------------------------------
// A directed table covers the reset matrix, field extremes, the zero and
// one w cases, and saturation. Random matrix loads and vertices follow over
// several tolerance settings and handshake idling patterns. Pass-through rows
// have fixed results; others check against the bench's bit-accurate model.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective_test;

    localparam int    DATA_W  = vtp_pkg::DATA_W;
    localparam int    IDX_W   = vtp_pkg::IDX_W;
    localparam int    TOL_W   = vtp_pkg::TOL_W;
    localparam int    MAT_N   = vtp_pkg::MAT_N;

    localparam int    FRAC    = 16;
    localparam longint ONE_Q  = 64'sd1 <<< FRAC;
    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     skip;
        logic                     sat;
    } vtx_result_t;

    typedef struct {
        logic                     op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        bit                       typed;
        vtx_result_t              res;
    } vtx_stim_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [TOL_W-1:0]         cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic                     cmd;
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] elem_value;
    logic signed [DATA_W-1:0] vertex_x;
    logic signed [DATA_W-1:0] vertex_y;
    logic signed [DATA_W-1:0] vertex_z;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     divide_skipped;
    logic                     saturated;

    // model state
    logic signed [DATA_W-1:0] matrix_copy [MAT_N];
    logic [TOL_W-1:0]         tol_copy;
    vtx_result_t              pending_results [$];
    vtx_stim_t                dir_tbl [$];
    int                       mismatch_count;
    int                       idle_in;
    int                       idle_out;

    vertex_transform_perspective u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .elem_index     (elem_index),
        .elem_value     (elem_value),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .vertex_z       (vertex_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .divide_skipped (divide_skipped),
        .saturated      (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // transform model
    // ------------------------------------------------------------------------
    function automatic longint clamp_s32(longint v, inout bit sat);
        if (v > LIM_HI)
        begin
            sat = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO)
        begin
            sat = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    function automatic longint row_dot(int r, longint x, longint y, longint z);
        int b;
        b = r * 4;
        return ((longint'(matrix_copy[b]) * x) >>> FRAC)
             + ((longint'(matrix_copy[b + 1]) * y) >>> FRAC)
             + ((longint'(matrix_copy[b + 2]) * z) >>> FRAC)
             + longint'(matrix_copy[b + 3]);
    endfunction

    function automatic longint fixed_divide(longint num, longint den, inout bit sat);
        bit                neg;
        bit                big;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   q;
        longint unsigned   r;
        longint            sq;
        neg = (num < 0) != (den < 0);
        big = 1'b0;
        a   = (num < 0) ? -num : num;
        b   = (den < 0) ? -den : den;
        if (a == 0)
            return 0;
        if (b == 0)
        begin
            sat = 1'b1;
            return neg ? LIM_LO : LIM_HI;
        end
        q = a / b;
        r = a % b;
        // long division for the fraction bits, 48-bit quotient register
        for (int i = 0; i < FRAC; i++)
        begin
            if (q > (64'd1 << 40))
                big = 1'b1;
            q = (q << 1) & ((64'd1 << 48) - 1);
            r = r << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        if (big || q > (64'd1 << 40))
            q = 64'd1 << 40;
        sq = neg ? -longint'(q) : longint'(q);
        return clamp_s32(sq, sat);
    endfunction

    function automatic vtx_result_t transform_vertex(longint x, longint y, longint z);
        vtx_result_t res;
        longint      w;
        longint      dw;
        longint      dw1;
        longint      s [3];
        bit          sat;
        bit          skip;
        sat = 1'b0;
        w   = row_dot(3, x, y, z);
        dw  = (w < 0) ? -w : w;
        dw1 = w - ONE_Q;
        if (dw1 < 0)
            dw1 = -dw1;
        skip = (dw < longint'(tol_copy)) || (dw1 < longint'(tol_copy));
        for (int i = 0; i < 3; i++)
        begin
            s[i] = row_dot(i, x, y, z);
            s[i] = skip ? clamp_s32(s[i], sat) : fixed_divide(s[i], w, sat);
        end
        res.x    = s[0][31:0];
        res.y    = s[1][31:0];
        res.z    = s[2][31:0];
        res.skip = skip;
        res.sat  = sat;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_item(vtx_stim_t s);
        // optional gap before the transfer
        if ($urandom_range(99) < idle_in)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_in);
        end
        in_valid   <= 1'b1;
        cmd        <= s.op;
        elem_index <= s.idx;
        elem_value <= s.val;
        vertex_x   <= s.x;
        vertex_y   <= s.y;
        vertex_z   <= s.z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer done: update the model
        if (s.op == vtp_pkg::CMD_LOAD)
            matrix_copy[s.idx] = s.val;
        else if (s.typed)
            pending_results.push_back(s.res);
        else
            pending_results.push_back(transform_vertex(s.x, s.y, s.z));
    endtask

    task automatic drain_and_set_tol(logic [TOL_W-1:0] tol);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tol_copy = tol;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_element();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'sd65536;
            2: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
            3: return $urandom;
            4: return 32'sd65536 + $signed($urandom_range(64)) - 32'sd32;
            default: return $signed($urandom_range(64)) - 32'sd32;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coord();
        if ($urandom_range(9) < 7)
            return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
        return $urandom;
    endfunction

    function automatic vtx_stim_t random_item();
        vtx_stim_t s;
        s.op    = ($urandom_range(99) < 25) ? vtp_pkg::CMD_LOAD : vtp_pkg::CMD_VERTEX;
        s.idx   = $urandom_range(15);
        s.val   = pick_element();
        s.x     = pick_coord();
        s.y     = pick_coord();
        s.z     = pick_coord();
        s.typed = 1'b0;
        s.res   = '{0, 0, 0, 0, 0};
        return s;
    endfunction

    function automatic vtx_stim_t load_row(int idx, logic signed [DATA_W-1:0] v);
        return '{vtp_pkg::CMD_LOAD, idx[IDX_W-1:0], v, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}};
    endfunction

    function automatic vtx_stim_t vtx_row(logic signed [DATA_W-1:0] x,
                                          logic signed [DATA_W-1:0] y,
                                          logic signed [DATA_W-1:0] z);
        return '{vtp_pkg::CMD_VERTEX, 4'd0, 0, x, y, z, 1'b0, '{0, 0, 0, 0, 0}};
    endfunction

    function automatic vtx_stim_t vtx_pass_row(logic signed [DATA_W-1:0] x,
                                               logic signed [DATA_W-1:0] y,
                                               logic signed [DATA_W-1:0] z);
        return '{vtp_pkg::CMD_VERTEX, 4'hf, 32'sh7fffffff, x, y, z, 1'b1,
                 '{x, y, z, 1'b1, 1'b0}};
    endfunction

    // ------------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        vtx_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_x !== want.x)
                        report_mismatch("out_x", out_x, want.x);
                    if (out_y !== want.y)
                        report_mismatch("out_y", out_y, want.y);
                    if (out_z !== want.z)
                        report_mismatch("out_z", out_z, want.z);
                    if (divide_skipped !== want.skip)
                        report_mismatch("divide_skipped", divide_skipped, want.skip);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end
            out_ready <= ($urandom_range(99) >= idle_out);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TOL_W-1:0] tol_set [6];
        mismatch_count = 0;
        idle_in        = 0;
        idle_out       = 0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        cmd        <= vtp_pkg::CMD_LOAD;
        elem_index <= '0;
        elem_value <= '0;
        vertex_x   <= '0;
        vertex_y   <= '0;
        vertex_z   <= '0;
        for (int i = 0; i < MAT_N; i++)
            matrix_copy[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
        tol_copy = vtp_pkg::TOL_RESET;

        // identity passes vertices through untouched, w exactly one
        dir_tbl.push_back(vtx_pass_row(0, 0, 0));
        dir_tbl.push_back(vtx_pass_row(32'sh7fffffff, 32'sh80000000, -1));
        dir_tbl.push_back(vtx_pass_row(32'sh80000000, 32'sh7fffffff, 1));
        // zero w is skipped, sums pass through
        dir_tbl.push_back(load_row(15, 0));
        dir_tbl.push_back(vtx_pass_row(32'sh50000, -3, 32'sh70000));
        // plain divide by two and by one half
        dir_tbl.push_back(load_row(15, 32'sh20000));
        dir_tbl.push_back(vtx_row(32'sh40000, -32'sh30000, 7));
        dir_tbl.push_back(load_row(15, 32'sh8000));
        dir_tbl.push_back(vtx_row(32'sh7fffffff, 32'sh80000000, 32'sh10000));
        // w just inside and just outside the tolerance around one
        dir_tbl.push_back(load_row(15, 32'sh10008));
        dir_tbl.push_back(vtx_row(32'sh12345, 32'sh6789a, -32'sh1000));
        dir_tbl.push_back(load_row(15, 32'sh10010));
        dir_tbl.push_back(vtx_row(32'sh12345, 32'sh6789a, -32'sh1000));
        // w near zero, negative side
        dir_tbl.push_back(load_row(15, -7));
        dir_tbl.push_back(vtx_row(32'sh10000, 32'sh20000, 32'sh30000));
        // extreme elements force saturation of the sums
        dir_tbl.push_back(load_row(0, 32'sh7fffffff));
        dir_tbl.push_back(load_row(5, 32'sh80000000));
        dir_tbl.push_back(load_row(15, 32'sh10000));
        dir_tbl.push_back(vtx_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        // large negative w from column zero of row four
        dir_tbl.push_back(load_row(12, 32'sh80000000));
        dir_tbl.push_back(vtx_row(32'sh10000, 32'sh80000000, 32'sh7fffffff));
        dir_tbl.push_back(load_row(12, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tol_set = '{vtp_pkg::TOL_RESET, 16'd0, 16'hffff, 16'd1,
                    16'($urandom), 16'($urandom)};
        foreach (dir_tbl[i])
            send_item(dir_tbl[i]);

        // six phases, two per idling pattern
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                drain_and_set_tol(tol_set[p]);
            idle_in  = (p / 2 == 0) ? 22 : (p / 2 == 1) ? 68 : 0;
            idle_out = (p / 2 == 0) ? 68 : (p / 2 == 1) ? 22 : 0;
            if (tol_set[p] == 0)
            begin
                // zero w with zero tolerance saturates nonzero sums to full scale
                send_item(load_row(12, 0));
                send_item(load_row(13, 0));
                send_item(load_row(14, 0));
                send_item(load_row(15, 0));
                send_item(vtx_row(32'sh10000, 32'sh10000, 32'sh10000));
                send_item(vtx_row(-32'sh10000, -32'sh10000, -32'sh10000));
                send_item(vtx_row(0, 0, 0));
            end
            for (int n = 0; n < 155; n++)
                send_item(random_item());
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/vtp_pkg.sv
hdl/vertex_transform_perspective.sv
sim/vertex_transform_perspective_test.sv
